// ===== rtl/core/lsm_pkg.sv =====
// shared types and constants of the latency statistics monitor
// no dependencies
package lsm_pkg;

  // sizes are tied to the fixed port widths of the top level
  localparam int NUM_CONTEXTS = 8;
  localparam int MAX_SAMPLES  = 2048;

  typedef logic [62:0] sample_t;

  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_CTX  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // handshake of the shared iterative units
  typedef struct packed {
    logic go;
    logic done;
  } unit_ctl_t;

endpackage

// ===== rtl/core/latency_statistics_monitor_top.sv =====
// latency statistics monitor top level: sequencer, context registers, result registers
// uses lsm_pkg, lsm_store, lsm_div, lsm_isqrt
//
// A request is taken when start is high and busy is low; its one result shows on the
// result ports for a single cycle with result_valid_o and cannot be held off. Create,
// start, a dropped end, an out-of-range context and a query of an empty context answer
// in the next cycle; an end that stores a sample steps through S_END_E, S_END_S and
// S_END_W (one shared 32x30 multiplier converts both stamps to nanoseconds, then the
// sample memory is written). A query on n samples takes one memory read per sample for
// the sum, two bit-serial divisions by n, a second pass with three 32x32 partial
// products per sample for the squared deviations, and a 32-step square root.
// The configuration channel is always ready; the user must write it only while the block is idle (not enforced).
module latency_statistics_monitor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_active_contexts_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [2:0]  context_index_i,
  input  logic [31:0] time_sec_i,
  input  logic [29:0] time_nsec_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [2:0]  granted_context_o,
  output logic [11:0] sample_count_o,
  output logic [62:0] mean_ns_o,
  output logic [63:0] variance_ns2_o,
  output logic [31:0] stddev_ns_o,
  output logic [62:0] last_sample_ns_o
);
  import lsm_pkg::*;

  localparam int CXW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int AW  = $clog2(NUM_CONTEXTS * MAX_SAMPLES);
  localparam int VW  = 126 + CW;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_END_E   = 5'd1;
  localparam logic [4:0] S_END_S   = 5'd2;
  localparam logic [4:0] S_END_W   = 5'd3;
  localparam logic [4:0] S_SUM     = 5'd4;
  localparam logic [4:0] S_SUM_W   = 5'd5;
  localparam logic [4:0] S_DIV1_GO = 5'd6;
  localparam logic [4:0] S_DIV1    = 5'd7;
  localparam logic [4:0] S_V_RD    = 5'd8;
  localparam logic [4:0] S_V_D     = 5'd9;
  localparam logic [4:0] S_V_M0    = 5'd10;
  localparam logic [4:0] S_V_M1    = 5'd11;
  localparam logic [4:0] S_V_M2    = 5'd12;
  localparam logic [4:0] S_V_M3    = 5'd13;
  localparam logic [4:0] S_DIV2_GO = 5'd14;
  localparam logic [4:0] S_DIV2    = 5'd15;
  localparam logic [4:0] S_SQRT_GO = 5'd16;
  localparam logic [4:0] S_SQRT    = 5'd17;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_33 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  logic [4:0]    state_q;
  logic [3:0]    active_q;
  logic          in_use_q [NUM_CONTEXTS];
  logic [61:0]   stamp_q  [NUM_CONTEXTS];
  logic [CW-1:0] cnt_q    [NUM_CONTEXTS];

  logic [CXW-1:0] ctx_q;
  logic [31:0]    sec_q;
  logic [29:0]    nsec_q;
  logic [AW-1:0]  base_q;
  logic [CW-1:0]  n_q, k_q;
  logic [62:0]    e_q, s_q, d_q, mean_q;
  logic [63:0]    prod_q, var_q;
  logic [1:0]     sh_q;
  logic [VW-1:0]  acc_q;
  logic           rvld_q;

  logic           res_vld_q;
  logic [1:0]     st_q;
  logic [2:0]     gr_q;
  logic [CW-1:0]  cnt_out_q;
  logic [62:0]    mean_out_q, last_q;
  logic [63:0]    var_out_q;
  logic [31:0]    sd_q;

  logic           accept, in_range, free_found;
  logic [CXW-1:0] ctx_in, free_idx;
  logic [CW-1:0]  n_in;
  logic [31:0]    mul_a;
  logic [29:0]    mul_b;
  logic [61:0]    ns_prod;
  logic [62:0]    sample;
  logic [31:0]    pm_a, pm_b;
  logic [VW-1:0]  prod_sh;

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  sample_t        mem_rdata;

  unit_ctl_t      div_in, div_out, sq_in, sq_out;
  logic [VW-1:0]  div_quo;
  logic [31:0]    root;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign in_range = (32'(context_index_i) < 32'(NUM_CONTEXTS));
  assign ctx_in   = CXW'(context_index_i);
  assign n_in     = in_range ? cnt_q[ctx_in] : '0;

  // lowest free context among the active ones
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_CONTEXTS; i++) begin
      if (!free_found && (32'(i) < 32'(active_q)) && !in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = CXW'(i);
      end
    end
  end

  // one multiplier shared by the end and start stamp conversions
  always_comb begin
    if (state_q == S_END_E) begin
      mul_a = sec_q;
      mul_b = nsec_q;
    end else begin
      mul_a = stamp_q[ctx_q][61:30];
      mul_b = stamp_q[ctx_q][29:0];
    end
    ns_prod = 62'(mul_a) * 62'(NS_PER_SEC);
  end

  assign sample = (e_q >= s_q) ? (e_q - s_q) : '0;

  // squared deviation partial products
  always_comb begin
    case (state_q)
      S_V_M0:  begin pm_a = d_q[31:0];         pm_b = d_q[31:0];         end
      S_V_M1:  begin pm_a = d_q[31:0];         pm_b = {1'b0, d_q[62:32]}; end
      default: begin pm_a = {1'b0, d_q[62:32]}; pm_b = {1'b0, d_q[62:32]}; end
    endcase
    case (sh_q)
      SH_0:    prod_sh = VW'(prod_q);
      SH_33:   prod_sh = VW'(prod_q) << 33;
      SH_64:   prod_sh = VW'(prod_q) << 64;
      default: prod_sh = '0;
    endcase
  end

  assign mem_we    = (state_q == S_END_W) && (n_q < CW'(MAX_SAMPLES));
  assign mem_waddr = base_q + AW'(n_q);
  assign mem_re    = (state_q == S_SUM) || (state_q == S_V_RD);
  assign mem_raddr = base_q + AW'(k_q);

  assign div_in.go   = (state_q == S_DIV1_GO) || (state_q == S_DIV2_GO);
  assign div_in.done = 1'b0;
  assign sq_in.go    = (state_q == S_SQRT_GO);
  assign sq_in.done  = 1'b0;

  lsm_store #(
    .Depth (NUM_CONTEXTS * MAX_SAMPLES),
    .Aw    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (sample),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lsm_div #(
    .W  (VW),
    .Nw (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_in),
    .ctl_o      (div_out),
    .dividend_i (acc_q),
    .divisor_i  (n_q),
    .quotient_o (div_quo)
  );

  lsm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sq_in),
    .ctl_o   (sq_out),
    .value_i (var_q),
    .root_o  (root)
  );

  // control and context state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= 4'd8;
      res_vld_q <= 1'b0;
      rvld_q    <= 1'b0;
      for (int i = 0; i < NUM_CONTEXTS; i++) begin
        in_use_q[i] <= 1'b0;
        stamp_q[i]  <= '0;
        cnt_q[i]    <= '0;
      end
    end else begin
      res_vld_q <= 1'b0;
      rvld_q    <= mem_re;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_active_contexts_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (action_i == ACT_CREATE) begin
              res_vld_q <= 1'b1;
              if (free_found) begin
                in_use_q[free_idx] <= 1'b1;
                cnt_q[free_idx]    <= '0;
              end
            end else if (!in_range) begin
              res_vld_q <= 1'b1;
            end else if (action_i == ACT_START) begin
              stamp_q[ctx_in] <= {time_sec_i, time_nsec_i};
              res_vld_q       <= 1'b1;
            end else if (action_i == ACT_END) begin
              if (n_in >= CW'(MAX_SAMPLES)) begin
                res_vld_q <= 1'b1;
              end else begin
                state_q <= S_END_E;
              end
            end else if (n_in == '0) begin
              res_vld_q <= 1'b1;
            end else begin
              state_q <= S_SUM;
            end
          end
        end
        S_END_E: state_q <= S_END_S;
        S_END_S: state_q <= S_END_W;
        S_END_W: begin
          cnt_q[ctx_q] <= n_q + 1'b1;
          res_vld_q    <= 1'b1;
          state_q      <= S_IDLE;
        end
        S_SUM: begin
          if (k_q == n_q - 1'b1) begin
            state_q <= S_SUM_W;
          end
        end
        S_SUM_W:   state_q <= S_DIV1_GO;
        S_DIV1_GO: state_q <= S_DIV1;
        S_DIV1: begin
          if (div_out.done) begin
            state_q <= S_V_RD;
          end
        end
        S_V_RD: state_q <= S_V_D;
        S_V_D:  state_q <= S_V_M0;
        S_V_M0: state_q <= S_V_M1;
        S_V_M1: state_q <= S_V_M2;
        S_V_M2: state_q <= S_V_M3;
        S_V_M3: state_q <= (k_q == n_q - 1'b1) ? S_DIV2_GO : S_V_RD;
        S_DIV2_GO: state_q <= S_DIV2;
        S_DIV2: begin
          if (div_out.done) begin
            state_q <= S_SQRT_GO;
          end
        end
        S_SQRT_GO: state_q <= S_SQRT;
        S_SQRT: begin
          if (sq_out.done) begin
            res_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctx_q      <= ctx_in;
          sec_q      <= time_sec_i;
          nsec_q     <= time_nsec_i;
          base_q     <= AW'(ctx_in * MAX_SAMPLES);
          n_q        <= n_in;
          k_q        <= '0;
          acc_q      <= '0;
          st_q       <= ST_OK;
          gr_q       <= '0;
          cnt_out_q  <= n_in;
          mean_out_q <= '0;
          var_out_q  <= '0;
          sd_q       <= '0;
          last_q     <= '0;
          if (action_i == ACT_CREATE) begin
            cnt_out_q <= '0;
            if (free_found) begin
              gr_q <= 3'(free_idx);
            end else begin
              st_q <= ST_NO_CTX;
            end
          end else if (action_i == ACT_END && in_range && n_in >= CW'(MAX_SAMPLES)) begin
            st_q <= ST_FULL;
          end
        end
      end
      S_END_E: e_q <= 63'(ns_prod) + 63'(mul_b);
      S_END_S: s_q <= 63'(ns_prod) + 63'(mul_b);
      S_END_W: cnt_out_q <= n_q + 1'b1;
      S_SUM: begin
        k_q <= k_q + 1'b1;
        if (rvld_q) begin
          acc_q <= acc_q + VW'(mem_rdata);
        end
      end
      S_SUM_W: begin
        acc_q  <= acc_q + VW'(mem_rdata);
        last_q <= mem_rdata;
        k_q    <= '0;
      end
      S_DIV1: begin
        if (div_out.done) begin
          mean_q <= div_quo[62:0];
          acc_q  <= '0;
        end
      end
      S_V_D: begin
        d_q <= (mem_rdata >= mean_q) ? (mem_rdata - mean_q) : (mean_q - mem_rdata);
      end
      S_V_M0: begin
        prod_q <= pm_a * pm_b;
        sh_q   <= SH_0;
      end
      S_V_M1: begin
        acc_q  <= acc_q + prod_sh;
        prod_q <= pm_a * pm_b;
        sh_q   <= SH_33;
      end
      S_V_M2: begin
        acc_q  <= acc_q + prod_sh;
        prod_q <= pm_a * pm_b;
        sh_q   <= SH_64;
      end
      S_V_M3: begin
        acc_q <= acc_q + prod_sh;
        k_q   <= k_q + 1'b1;
      end
      S_DIV2: begin
        if (div_out.done) begin
          // saturate when the quotient does not fit 64 bits
          var_q <= (|div_quo[VW-1:64]) ? '1 : div_quo[63:0];
        end
      end
      S_SQRT: begin
        if (sq_out.done) begin
          mean_out_q <= mean_q;
          var_out_q  <= var_q;
          sd_q       <= root;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o    = res_vld_q;
  assign status_o          = st_q;
  assign granted_context_o = gr_q;
  assign sample_count_o    = 12'(cnt_out_q);
  assign mean_ns_o         = mean_out_q;
  assign variance_ns2_o    = var_out_q;
  assign stddev_ns_o       = sd_q;
  assign last_sample_ns_o  = last_q;

  // a result follows a request taken or work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept) || $past(busy))
    else $error("result without a request");

  // the divider only finishes while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_out.done |-> (state_q == S_DIV1) || (state_q == S_DIV2))
    else $error("divider done outside a division state");

  // failed requests carry no statistics
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |->
      (mean_ns_o == '0) && (variance_ns2_o == '0) && (stddev_ns_o == '0))
    else $error("statistics on a failed request");

  // the sample memory is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("sample memory read and write overlap");

endmodule

// ===== rtl/core/lsm_store.sv =====
// sample memory: one write port, one read port, registered read data
// uses lsm_pkg
module lsm_store #(
  parameter int Depth = 16384,
  parameter int Aw    = 14
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [Aw-1:0]  waddr_i,
  input  lsm_pkg::sample_t wdata_i,
  input  logic           re_i,
  input  logic [Aw-1:0]  raddr_i,
  output lsm_pkg::sample_t rdata_o
);
  import lsm_pkg::*;

  sample_t mem [Depth];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lsm_div.sv =====
// restoring divider, one quotient bit per cycle
// uses lsm_pkg
module lsm_div #(
  parameter int W  = 138,
  parameter int Nw = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsm_pkg::unit_ctl_t ctl_i,
  output lsm_pkg::unit_ctl_t ctl_o,
  input  logic [W-1:0]      dividend_i,
  input  logic [Nw-1:0]     divisor_i,
  output logic [W-1:0]      quotient_o
);
  import lsm_pkg::*;

  localparam int Cw = $clog2(W + 1);

  logic [W-1:0]  quo_q;
  logic [Nw:0]   rem_q;
  logic [Nw-1:0] dvs_q;
  logic [Cw-1:0] cnt_q;
  logic          run_q, done_q;
  logic [Nw:0]   rem_sh;
  logic          qbit;

  always_comb begin
    rem_sh = {rem_q[Nw-1:0], quo_q[W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.go) begin
        run_q <= 1'b1;
        cnt_q <= Cw'(W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == Cw'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.go) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[W-2:0], qbit};
    end
  end

  assign quotient_o = quo_q;
  assign ctl_o.go   = run_q;
  assign ctl_o.done = done_q;

endmodule

// ===== rtl/core/lsm_isqrt.sv =====
// floor square root of a 64-bit value, two radicand bits per cycle
// uses lsm_pkg
module lsm_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsm_pkg::unit_ctl_t ctl_i,
  output lsm_pkg::unit_ctl_t ctl_o,
  input  logic [63:0]       value_i,
  output logic [31:0]       root_o
);
  import lsm_pkg::*;

  logic [63:0] rad_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [35:0] rem_sh, trial;
  logic        take;

  always_comb begin
    rem_sh = {rem_q[33:0], rad_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.go) begin
        run_q <= 1'b1;
        cnt_q <= 6'd32;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.go) begin
      rad_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[30:0], take};
    end
  end

  assign root_o     = root_q;
  assign ctl_o.go   = run_q;
  assign ctl_o.done = done_q;

endmodule

// ===== tb/tb_latency_statistics_monitor_top.sv =====
`timescale 1ns / 100ps
// testbench of the latency statistics monitor: directed table, store fill, random phases
// results are checked against typed rows or an in-bench context model; uses lsm_pkg
module tb_latency_statistics_monitor_top;
  import lsm_pkg::*;

  localparam int NCTX       = 8;
  localparam int STORE_MAX  = 2048;
  localparam int CYCLE_CAP  = 3000000;
  localparam int RAND_ITEMS = 1050;

  typedef struct {
    logic [1:0]  action;
    logic [2:0]  ctx;
    logic [31:0] sec;
    logic [29:0] nsec;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [2:0]  granted;
    logic [11:0] count;
    logic [62:0] mean;
    logic [63:0] variance;
    logic [31:0] sdev;
    logic [62:0] last;
  } stats_t;

  // directed row: typed marks rows whose result is written out by hand
  typedef struct {
    request_t   req;
    bit         typed;
    logic [1:0] status;
    logic [2:0] granted;
    logic [11:0] count;
  } row_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_active_contexts_i = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  action_i = 0;
  logic [2:0]  context_index_i = 0;
  logic [31:0] time_sec_i = 0;
  logic [29:0] time_nsec_i = 0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [2:0]  granted_context_o;
  logic [11:0] sample_count_o;
  logic [62:0] mean_ns_o;
  logic [63:0] variance_ns2_o;
  logic [31:0] stddev_ns_o;
  logic [62:0] last_sample_ns_o;

  latency_statistics_monitor_top u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_active_contexts_i,
    .start, .busy, .action_i, .context_index_i, .time_sec_i, .time_nsec_i,
    .result_valid_o, .status_o, .granted_context_o, .sample_count_o,
    .mean_ns_o, .variance_ns2_o, .stddev_ns_o, .last_sample_ns_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // model state
  logic [3:0]  active_cnt;
  bit          ctx_claimed [NCTX];
  logic [61:0] start_stamp [NCTX];
  sample_t     latencies [NCTX][$];

  stats_t pending_stats [$];
  int     errors = 0;
  int     cycles = 0;
  int     n_results = 0;
  int     n_full = 0;
  int     n_sat = 0;

  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] stamp_ns(logic [31:0] sec, logic [29:0] nsec);
    return {32'd0, sec} * 64'd1000000000 + {34'd0, nsec};
  endfunction

  task automatic predict_latency(input request_t rq, output stats_t r);
    logic [127:0] sum;
    logic [191:0] sq;
    logic [191:0] qv;
    logic [63:0]  s_ns;
    logic [63:0]  e_ns;
    logic [62:0]  d;
    int           n;
    r = '{default: '0};
    n = latencies[rq.ctx].size();
    case (rq.action)
      ACT_CREATE: begin
        r.status = ST_NO_CTX;
        for (int i = 0; i < NCTX && i < active_cnt; i++) begin
          if (!ctx_claimed[i]) begin
            ctx_claimed[i] = 1;
            latencies[i].delete();
            r.granted = 3'(i);
            r.status = ST_OK;
            break;
          end
        end
      end
      ACT_START: begin
        start_stamp[rq.ctx] = {rq.sec, rq.nsec};
        r.count = 12'(n);
      end
      ACT_END: begin
        if (n >= STORE_MAX) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          s_ns = stamp_ns(start_stamp[rq.ctx][61:30], start_stamp[rq.ctx][29:0]);
          e_ns = stamp_ns(rq.sec, rq.nsec);
          latencies[rq.ctx].push_back(e_ns >= s_ns ? sample_t'(e_ns - s_ns) : '0);
        end
        r.count = 12'(latencies[rq.ctx].size());
      end
      default: begin
        r.count = 12'(n);
        if (n > 0) begin
          sum = 0;
          foreach (latencies[rq.ctx][k]) sum += latencies[rq.ctx][k];
          sum = sum / n;
          r.mean = sum[62:0];
          sq = 0;
          foreach (latencies[rq.ctx][k]) begin
            d = latencies[rq.ctx][k] >= r.mean ? latencies[rq.ctx][k] - r.mean
                                                : r.mean - latencies[rq.ctx][k];
            sq += {129'd0, d} * {129'd0, d};
          end
          qv = sq / n;
          if (qv[191:64] != 0) begin
            r.variance = '1;
            n_sat++;
          end else begin
            r.variance = qv[63:0];
          end
          r.sdev = floor_sqrt(r.variance);
          r.last = latencies[rq.ctx][n-1];
        end
      end
    endcase
  endtask

  // sender: entered and left at a falling edge
  task automatic issue_request(input request_t rq, input int gap, input row_t row);
    stats_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i        <= rq.action;
    context_index_i <= rq.ctx;
    time_sec_i      <= rq.sec;
    time_nsec_i     <= rq.nsec;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_latency(rq, r);
    if (row.typed) begin
      r = '{default: '0};
      r.status  = row.status;
      r.granted = row.granted;
      r.count   = row.count;
    end
    pending_stats.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_active(input logic [3:0] val);
    cfg_valid_i           <= 1'b1;
    cfg_active_contexts_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    active_cnt = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic check_field(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    stats_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: run exceeded the cycle limit", $time);
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d", $time, status_o);
      end else begin
        e = pending_stats.pop_front();
        check_field("status", 64'(e.status), 64'(status_o));
        check_field("granted_context", 64'(e.granted), 64'(granted_context_o));
        check_field("sample_count", 64'(e.count), 64'(sample_count_o));
        check_field("mean_ns", 64'(e.mean), 64'(mean_ns_o));
        check_field("variance_ns2", e.variance, variance_ns2_o);
        check_field("stddev_ns", 64'(e.sdev), 64'(stddev_ns_o));
        check_field("last_sample_ns", 64'(e.last), 64'(last_sample_ns_o));
      end
    end
  end

  function automatic request_t mk(logic [1:0] a, logic [2:0] c, logic [31:0] s,
                                  logic [29:0] ns);
    request_t q;
    q.action = a; q.ctx = c; q.sec = s; q.nsec = ns;
    return q;
  endfunction

  function automatic request_t random_request();
    request_t q;
    int pick;
    q = mk(2'($urandom), 3'($urandom), $urandom, 30'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 10) return q;                       // noise
    q.nsec = (pick % 7 == 0) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
    if (pick < 45) begin
      q.action = ACT_START;
    end else if (pick < 82) begin
      q.action = ACT_END;
      if (pick % 9 != 0) q.sec = start_stamp[q.ctx][61:30] + $urandom_range(0, 3);
    end else if (pick < 95) begin
      q.action = ACT_QUERY;
      // the full context is slow to query, keep it rare
      if (q.ctx == 0 && $urandom_range(0, 3) != 0) q.ctx = 3'($urandom_range(1, NCTX - 1));
    end else begin
      q.action = ACT_CREATE;
    end
    return q;
  endfunction

  row_t dir_rows [$];
  row_t plain;
  logic [3:0] phase_cfg [5] = '{4'd0, 4'd1, 4'd15, 4'd8, 4'd5};

  task automatic add_row(input request_t q, input bit typed = 0, input logic [1:0] st = 0,
                         input logic [2:0] g = 0, input logic [11:0] c = 0);
    row_t r;
    r.req = q; r.typed = typed; r.status = st; r.granted = g; r.count = c;
    dir_rows.push_back(r);
  endtask

  initial begin
    int per_phase;
    plain = '{default: '0};
    active_cnt = 4'd8;
    foreach (ctx_claimed[i]) begin
      ctx_claimed[i] = 0;
      start_stamp[i] = '0;
    end

    add_row(mk(ACT_QUERY, 3, 0, 0), 1, ST_OK, 0, 0);          // empty context after reset
    add_row(mk(ACT_CREATE, 0, 0, 0), 1, ST_OK, 0, 0);
    add_row(mk(ACT_CREATE, 5, 0, 0), 1, ST_OK, 1, 0);
    add_row(mk(ACT_START, 0, 0, 0));
    add_row(mk(ACT_END, 0, 32'hFFFF_FFFF, 30'd999999999));     // largest sample
    add_row(mk(ACT_START, 0, 5, 30'd999999999));
    add_row(mk(ACT_END, 0, 6, 0));                             // nanosecond borrow
    add_row(mk(ACT_END, 0, 4, 0));                             // end before start
    add_row(mk(ACT_QUERY, 0, 0, 0));                           // saturating variance
    add_row(mk(ACT_START, 1, 0, 30'h3FFF_FFFF));               // nanoseconds out of range
    add_row(mk(ACT_END, 1, 2, 30'h2AAA_AAAA));
    add_row(mk(ACT_END, 1, 9, 30'h1555_5555));
    add_row(mk(ACT_QUERY, 1, 0, 0));
    add_row(mk(ACT_START, 7, 32'h8000_0000, 30'd12345));       // unclaimed context
    add_row(mk(ACT_END, 7, 32'h8000_0001, 30'd5));
    add_row(mk(ACT_QUERY, 7, 0, 0));
    for (int i = 2; i < NCTX; i++) add_row(mk(ACT_CREATE, 0, 0, 0), 1, ST_OK, 3'(i), 0);
    add_row(mk(ACT_CREATE, 0, 0, 0), 1, ST_NO_CTX, 0, 0);      // no free context

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_active(4'd8);
    foreach (dir_rows[i]) issue_request(dir_rows[i].req, draw_gap(), dir_rows[i]);
    drain_results();

    // fill context 0 to the limit, then two dropped ends
    issue_request(mk(ACT_START, 0, 100, 0), 0, plain);
    while (latencies[0].size() < STORE_MAX)
      issue_request(mk(ACT_END, 0, 32'(100 + $urandom_range(0, 2)),
                       30'($urandom_range(0, 999999999))), 0, plain);
    repeat (2) issue_request(mk(ACT_END, 0, 101, 0), draw_gap(), plain);
    issue_request(mk(ACT_QUERY, 0, 0, 0), 0, plain);
    drain_results();

    per_phase = RAND_ITEMS / 5;
    foreach (phase_cfg[p]) begin
      write_active(p == 4 ? 4'($urandom_range(1, 7)) : phase_cfg[p]);
      for (int i = 0; i < per_phase; i++) begin
        if (p == 2 && i == per_phase / 2) drain_results();    // hold off until all back
        issue_request(random_request(), (p == 3) ? 0 : draw_gap(), plain);
      end
      drain_results();
    end

    $display("%0d results checked, %0d dropped ends, %0d saturated variances",
             n_results, n_full, n_sat);
    $display("covered creates, starts, ends, queries over %0d register settings", 6);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
